/* hdl/tcu_pkg.sv */
package tcu_pkg;

	// Coordinate width of one raw fixed-point field.
	localparam int CW = 32;
	// Vertex difference width.
	localparam int DW = CW + 1;
	// Squared norm of a vertex, unsigned.
	localparam int SW = 2 * CW;
	// Product of a coordinate and a difference.
	localparam int PW = 2 * CW + 1;
	// Product of two differences, or of a 33-bit slice and a difference.
	localparam int PPW = 2 * DW;
	// Doubled determinant.
	localparam int DETW = 2 * CW + 3;
	// Center numerators.
	localparam int NW = 3 * CW + 2;
	// Quotient bits developed before rounding.
	localparam int QW = CW + 1;
	// Squared distance and square root remainder.
	localparam int BW = 2 * CW + 5;
	// Square root bits.
	localparam int RB = CW + 2;

	typedef struct packed {
		logic [2:0][CW-1:0] x;
		logic [2:0][CW-1:0] y;
		logic               coll;
	} tcu_side_t;

	typedef struct packed {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic          sat;
	} tcu_ctr_t;

	typedef struct packed {
		logic [CW-1:0] center_x;
		logic [CW-1:0] center_y;
		logic [CW-1:0] radius;
		logic          coll;
		logic          sat;
	} tcu_res_t;

endpackage

/* hdl/triangle_circumcircle_unit_top.sv */
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid / in_stall   ax, ay, bx, by_coord, cx_in, cy_in
// out      output     out_valid / out_stall center_x, center_y, radius, collinear, saturated
//
// One beat enters per cycle and one leaves per cycle while neither side stalls. From input
// acceptance to out_valid a beat passes 5 front stages, 35 divider stages (one per
// quotient bit plus abs and round), 40 radius stages (one per root bit plus
// distance, max and round), and the output register.
// Reset clears only the valid bits and the skid flag; payload is not reset.
// A stalled output beat is held in the output register while the pipeline
// keeps moving; the next beat parks in a skid register, and only then does
// in_stall rise and the whole pipeline freeze.
module triangle_circumcircle_unit_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [tcu_pkg::CW-1:0] ax,
	input  logic [tcu_pkg::CW-1:0] ay,
	input  logic [tcu_pkg::CW-1:0] bx,
	input  logic [tcu_pkg::CW-1:0] by_coord,
	input  logic [tcu_pkg::CW-1:0] cx_in,
	input  logic [tcu_pkg::CW-1:0] cy_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [tcu_pkg::CW-1:0] center_x,
	output logic [tcu_pkg::CW-1:0] center_y,
	output logic [tcu_pkg::CW-1:0] radius,
	output logic                   collinear,
	output logic                   saturated
);
	import tcu_pkg::*;

	// The pipeline advances as a whole whenever the skid register is free.
	logic                   en;

	logic                   f_vld;
	logic signed [NW-1:0]   f_nx, f_ny;
	logic signed [DETW-1:0] f_det;
	tcu_side_t              f_side;

	logic                   d_vld;
	tcu_ctr_t               d_ctr;
	tcu_side_t              d_side;

	logic                   r_vld;
	tcu_res_t               r_res;

	logic                   out_v_q, sk_v_q;
	tcu_res_t               out_q, sk_q;

	assign en = !sk_v_q;

	// Norms, determinant and center numerators.
	tcu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by_coord (by_coord),
		.cx_in    (cx_in),
		.cy_in    (cy_in),
		.vld_o    (f_vld),
		.nx       (f_nx),
		.ny       (f_ny),
		.det      (f_det),
		.side     (f_side)
	);

	// Both center coordinates are divided side by side in the same stages.
	tcu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (f_vld),
		.nx     (f_nx),
		.ny     (f_ny),
		.det    (f_det),
		.side_i (f_side),
		.vld_o  (d_vld),
		.ctr    (d_ctr),
		.side_o (d_side)
	);

	// Largest vertex distance to the rounded center and its square root.
	tcu_rad u_rad (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (d_vld),
		.ctr    (d_ctr),
		.side   (d_side),
		.vld_o  (r_vld),
		.res    (r_res)
	);

	// Output register with a one-entry skid behind it. The skid fills only
	// when a new beat arrives while the output is held by out_stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			out_v_q <= sk_v_q | r_vld;
			sk_v_q  <= 1'b0;
		end else if (en && r_vld) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= sk_v_q ? sk_q : r_res;
		end else if (en && r_vld) begin
			sk_q <= r_res;
		end
	end

	assign in_stall  = sk_v_q;
	assign out_valid = out_v_q;
	assign center_x  = out_q.center_x;
	assign center_y  = out_q.center_y;
	assign radius    = out_q.radius;
	assign collinear = out_q.coll;
	assign saturated = out_q.sat;

endmodule

/* hdl/tcu_front.sv */
module tcu_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [tcu_pkg::CW-1:0]           ax,
	input  logic [tcu_pkg::CW-1:0]           ay,
	input  logic [tcu_pkg::CW-1:0]           bx,
	input  logic [tcu_pkg::CW-1:0]           by_coord,
	input  logic [tcu_pkg::CW-1:0]           cx_in,
	input  logic [tcu_pkg::CW-1:0]           cy_in,
	output logic                             vld_o,
	output logic signed [tcu_pkg::NW-1:0]    nx,
	output logic signed [tcu_pkg::NW-1:0]    ny,
	output logic signed [tcu_pkg::DETW-1:0]  det,
	output tcu_pkg::tcu_side_t               side
);
	import tcu_pkg::*;

	logic signed [CW-1:0]   xi [3];
	logic signed [CW-1:0]   yi [3];
	logic signed [DW-1:0]   dyc [3];
	logic signed [DW-1:0]   dxc [3];
	logic signed [SW-1:0]   sqxc [3];
	logic signed [SW-1:0]   sqyc [3];

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CW-1:0]   x_s1 [3], y_s1 [3];
	logic signed [DW-1:0]   dy_s1 [3], dx_s1 [3];
	logic signed [SW-1:0]   sqx_s1 [3], sqy_s1 [3];

	logic signed [PW-1:0]   pdc [3];
	logic signed [CW-1:0]   x_s2 [3], y_s2 [3];
	logic signed [DW-1:0]   dy_s2 [3], dx_s2 [3];
	logic [SW-1:0]          s_s2 [3];
	logic signed [PW-1:0]   pd_s2 [3];

	logic signed [DETW-1:0] detsum;
	logic signed [PPW-1:0]  plxc [3], phxc [3], plyc [3], phyc [3];
	logic signed [CW-1:0]   x_s3 [3], y_s3 [3];
	logic signed [DETW-1:0] det_s3;
	logic signed [PPW-1:0]  plx_s3 [3], phx_s3 [3], ply_s3 [3], phy_s3 [3];

	logic signed [CW-1:0]   x_s4 [3], y_s4 [3];
	logic signed [DETW-1:0] det_s4;
	logic                   coll_s4;
	logic signed [NW-1:0]   tx_s4 [3], ty_s4 [3];

	logic signed [CW-1:0]   x_s5 [3], y_s5 [3];
	logic signed [DETW-1:0] det_s5;
	logic                   coll_s5;
	logic signed [NW-1:0]   nx_s5, ny_s5;

	always_comb begin
		xi[0] = ax;
		xi[1] = bx;
		xi[2] = cx_in;
		yi[0] = ay;
		yi[1] = by_coord;
		yi[2] = cy_in;
		dyc[0] = DW'(yi[1]) - DW'(yi[2]);
		dyc[1] = DW'(yi[2]) - DW'(yi[0]);
		dyc[2] = DW'(yi[0]) - DW'(yi[1]);
		dxc[0] = DW'(xi[2]) - DW'(xi[1]);
		dxc[1] = DW'(xi[0]) - DW'(xi[2]);
		dxc[2] = DW'(xi[1]) - DW'(xi[0]);
		for (int i = 0; i < 3; i++) begin
			sqxc[i] = xi[i] * xi[i];
			sqyc[i] = yi[i] * yi[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pdc[i] = x_s1[i] * dy_s1[i];
		end
	end

	// Each 64-bit norm is split into two 33-bit signed slices.
	always_comb begin
		detsum = DETW'(pd_s2[0]) + DETW'(pd_s2[1]) + DETW'(pd_s2[2]);
		for (int i = 0; i < 3; i++) begin
			plxc[i] = $signed({1'b0, s_s2[i][CW-1:0]}) * dy_s2[i];
			phxc[i] = $signed({1'b0, s_s2[i][SW-1:CW]}) * dy_s2[i];
			plyc[i] = $signed({1'b0, s_s2[i][CW-1:0]}) * dx_s2[i];
			phyc[i] = $signed({1'b0, s_s2[i][SW-1:CW]}) * dx_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				x_s1[i]   <= xi[i];
				y_s1[i]   <= yi[i];
				dy_s1[i]  <= dyc[i];
				dx_s1[i]  <= dxc[i];
				sqx_s1[i] <= sqxc[i];
				sqy_s1[i] <= sqyc[i];

				x_s2[i]  <= x_s1[i];
				y_s2[i]  <= y_s1[i];
				dy_s2[i] <= dy_s1[i];
				dx_s2[i] <= dx_s1[i];
				s_s2[i]  <= $unsigned(sqx_s1[i]) + $unsigned(sqy_s1[i]);
				pd_s2[i] <= pdc[i];

				x_s3[i]   <= x_s2[i];
				y_s3[i]   <= y_s2[i];
				plx_s3[i] <= plxc[i];
				phx_s3[i] <= phxc[i];
				ply_s3[i] <= plyc[i];
				phy_s3[i] <= phyc[i];

				x_s4[i]  <= x_s3[i];
				y_s4[i]  <= y_s3[i];
				tx_s4[i] <= (NW'(phx_s3[i]) <<< CW) + NW'(plx_s3[i]);
				ty_s4[i] <= (NW'(phy_s3[i]) <<< CW) + NW'(ply_s3[i]);

				x_s5[i] <= x_s4[i];
				y_s5[i] <= y_s4[i];
			end
			det_s3  <= detsum <<< 1;
			det_s4  <= det_s3;
			coll_s4 <= (det_s3 == '0);
			det_s5  <= det_s4;
			coll_s5 <= coll_s4;
			nx_s5   <= tx_s4[0] + tx_s4[1] + tx_s4[2];
			ny_s5   <= ty_s4[0] + ty_s4[1] + ty_s4[2];
		end
	end

	always_comb begin
		vld_o = vld_s5;
		nx    = nx_s5;
		ny    = ny_s5;
		det   = det_s5;
		for (int i = 0; i < 3; i++) begin
			side.x[i] = x_s5[i];
			side.y[i] = y_s5[i];
		end
		side.coll = coll_s5;
	end

endmodule

/* hdl/tcu_div.sv */
module tcu_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic signed [tcu_pkg::NW-1:0]   nx,
	input  logic signed [tcu_pkg::NW-1:0]   ny,
	input  logic signed [tcu_pkg::DETW-1:0] det,
	input  tcu_pkg::tcu_side_t              side_i,
	output logic                            vld_o,
	output tcu_pkg::tcu_ctr_t               ctr,
	output tcu_pkg::tcu_side_t              side_o
);
	import tcu_pkg::*;

	// Rounded, saturated quotient: the top bit is the clip flag.
	function automatic logic [CW:0] clip(input logic [QW:0] q, input logic neg,
		input logic ov);
		logic [QW:0] lim;
		lim = (QW+1)'(1) << (CW - 1);
		if (neg) begin
			if (ov || q > lim) clip = {1'b1, 1'b1, {(CW-1){1'b0}}};
			else clip = {1'b0, CW'(-q)};
		end else begin
			if (ov || q > lim - (QW+1)'(1)) clip = {1'b1, 1'b0, {(CW-1){1'b1}}};
			else clip = {1'b0, q[CW-1:0]};
		end
	endfunction

	logic [NW-1:0]   absx, absy;
	logic [DETW-1:0] absd;

	logic            vld_s [0:QW];
	logic [NW-1:0]   rx_s [0:QW], ry_s [0:QW];
	logic [QW-1:0]   qx_s [0:QW], qy_s [0:QW];
	logic [DETW-1:0] ad_s [0:QW];
	logic            negx_s [0:QW], negy_s [0:QW];
	logic            ovx_s [0:QW], ovy_s [0:QW];
	tcu_side_t       side_s [0:QW];

	logic            rndx, rndy;
	logic [QW:0]     qrx, qry;
	logic [CW:0]     cxr, cyr;

	logic            vld_sf;
	tcu_ctr_t        ctr_sf;
	tcu_side_t       side_sf;

	always_comb begin
		absx = nx[NW-1] ? -nx : nx;
		absy = ny[NW-1] ? -ny : ny;
		absd = det[DETW-1] ? -det : det;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_vld;
	end

	// Quotients at or above 2^QW are flagged up front and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= absx;
			ry_s[0]   <= absy;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			ad_s[0]   <= absd;
			negx_s[0] <= nx[NW-1] ^ det[DETW-1];
			negy_s[0] <= ny[NW-1] ^ det[DETW-1];
			ovx_s[0]  <= {1'b0, absx} >= ((NW+1)'(absd) << QW);
			ovy_s[0]  <= {1'b0, absy} >= ((NW+1)'(absd) << QW);
			side_s[0] <= side_i;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int K = QW - 1 - j;
		logic [NW-1:0] dsh;
		logic          gx, gy;

		assign dsh = NW'(ad_s[j]) << K;
		assign gx  = rx_s[j] >= dsh;
		assign gy  = ry_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j+1] <= 1'b0;
			else if (en) vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1]   <= gx ? rx_s[j] - dsh : rx_s[j];
				ry_s[j+1]   <= gy ? ry_s[j] - dsh : ry_s[j];
				qx_s[j+1]   <= qx_s[j] | (QW'(gx) << K);
				qy_s[j+1]   <= qy_s[j] | (QW'(gy) << K);
				ad_s[j+1]   <= ad_s[j];
				negx_s[j+1] <= negx_s[j];
				negy_s[j+1] <= negy_s[j];
				ovx_s[j+1]  <= ovx_s[j];
				ovy_s[j+1]  <= ovy_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	// Round half away from zero on the magnitude, then clip.
	always_comb begin
		rndx = {rx_s[QW], 1'b0} >= (NW+1)'(ad_s[QW]);
		rndy = {ry_s[QW], 1'b0} >= (NW+1)'(ad_s[QW]);
		qrx  = (QW+1)'(qx_s[QW]) + (QW+1)'(rndx);
		qry  = (QW+1)'(qy_s[QW]) + (QW+1)'(rndy);
		cxr  = clip(qrx, negx_s[QW], ovx_s[QW]);
		cyr  = clip(qry, negy_s[QW], ovy_s[QW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sf <= 1'b0;
		else if (en) vld_sf <= vld_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctr_sf.cx  <= cxr[CW-1:0];
			ctr_sf.cy  <= cyr[CW-1:0];
			ctr_sf.sat <= cxr[CW] | cyr[CW];
			side_sf    <= side_s[QW];
		end
	end

	assign vld_o  = vld_sf;
	assign ctr    = ctr_sf;
	assign side_o = side_sf;

endmodule

/* hdl/tcu_rad.sv */
module tcu_rad (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  tcu_pkg::tcu_ctr_t  ctr,
	input  tcu_pkg::tcu_side_t side,
	output logic               vld_o,
	output tcu_pkg::tcu_res_t  res
);
	import tcu_pkg::*;

	logic signed [DW-1:0]  exc [3], eyc [3];
	logic signed [PPW-1:0] sqxc [3], sqyc [3];

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	tcu_ctr_t              ctr_s1, ctr_s2, ctr_s3, ctr_s4;
	logic                  coll_s1, coll_s2, coll_s3, coll_s4;
	logic signed [DW-1:0]  ex_s1 [3], ey_s1 [3];
	logic signed [PPW-1:0] sqx_s2 [3], sqy_s2 [3];
	logic [BW-1:0]         dist_s3 [3];
	logic [BW-1:0]         m01_s4, d2_s4;

	logic                  vld_s [0:RB];
	logic [BW-1:0]         rem_s [0:RB];
	logic [RB-1:0]         root_s [0:RB];
	tcu_ctr_t              ctr_s [0:RB];
	logic                  coll_s [0:RB];

	logic                  rnd, satr;
	logic [RB:0]           rr;

	logic                  vld_sf;
	tcu_res_t              res_sf;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			exc[i]  = DW'($signed(side.x[i])) - DW'($signed(ctr.cx));
			eyc[i]  = DW'($signed(side.y[i])) - DW'($signed(ctr.cy));
			sqxc[i] = ex_s1[i] * ex_s1[i];
			sqyc[i] = ey_s1[i] * ey_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_vld;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ex_s1[i]   <= exc[i];
				ey_s1[i]   <= eyc[i];
				sqx_s2[i]  <= sqxc[i];
				sqy_s2[i]  <= sqyc[i];
				dist_s3[i] <= BW'($unsigned(sqx_s2[i])) + BW'($unsigned(sqy_s2[i]));
			end
			ctr_s1  <= ctr;
			coll_s1 <= side.coll;
			ctr_s2  <= ctr_s1;
			coll_s2 <= coll_s1;
			ctr_s3  <= ctr_s2;
			coll_s3 <= coll_s2;
			m01_s4  <= (dist_s3[1] > dist_s3[0]) ? dist_s3[1] : dist_s3[0];
			d2_s4   <= dist_s3[2];
			ctr_s4  <= ctr_s3;
			coll_s4 <= coll_s3;
			rem_s[0]  <= (d2_s4 > m01_s4) ? d2_s4 : m01_s4;
			root_s[0] <= '0;
			ctr_s[0]  <= ctr_s4;
			coll_s[0] <= coll_s4;
		end
	end

	// Digit-by-digit square root, one root bit per stage.
	for (genvar j = 0; j < RB; j++) begin : g_root
		localparam int B = RB - 1 - j;
		logic [BW-1:0] trial;
		logic          ge;

		assign trial = (BW'(root_s[j]) << (B + 1)) | (BW'(1'b1) << (2 * B));
		assign ge    = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j+1] <= 1'b0;
			else if (en) vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= root_s[j] | (RB'(ge) << B);
				ctr_s[j+1]  <= ctr_s[j];
				coll_s[j+1] <= coll_s[j];
			end
		end
	end

	always_comb begin
		rnd  = rem_s[RB] > BW'(root_s[RB]);
		rr   = (RB+1)'(root_s[RB]) + (RB+1)'(rnd);
		satr = |rr[RB:CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sf <= 1'b0;
		else if (en) vld_sf <= vld_s[RB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (coll_s[RB]) begin
				res_sf.center_x <= '0;
				res_sf.center_y <= '0;
				res_sf.radius   <= '0;
				res_sf.coll     <= 1'b1;
				res_sf.sat      <= 1'b0;
			end else begin
				res_sf.center_x <= ctr_s[RB].cx;
				res_sf.center_y <= ctr_s[RB].cy;
				res_sf.radius   <= satr ? {CW{1'b1}} : rr[CW-1:0];
				res_sf.coll     <= 1'b0;
				res_sf.sat      <= ctr_s[RB].sat | satr;
			end
		end
	end

	assign vld_o = vld_sf;
	assign res   = res_sf;

endmodule

/* hdl/tcu_checker.sv */
module tcu_props (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [tcu_pkg::CW-1:0] center_x,
	input logic [tcu_pkg::CW-1:0] center_y,
	input logic [tcu_pkg::CW-1:0] radius,
	input logic                   collinear,
	input logic                   saturated
);
	import tcu_pkg::*;

	logic cx_edge, cy_edge;

	assign cx_edge = (center_x[CW-1] && center_x[CW-2:0] == '0) ||
		(!center_x[CW-1] && &center_x[CW-2:0]);
	assign cy_edge = (center_y[CW-1] && center_y[CW-2:0] == '0) ||
		(!center_y[CW-1] && &center_y[CW-2:0]);

	// A held output beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// A degenerate triangle reports all zeros.
	a_coll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collinear |-> center_x == '0 && center_y == '0 &&
		radius == '0 && !saturated)
		else $error("collinear beat carries nonzero results");

	// Distinct vertices always leave a vertex off the integer center.
	a_rad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !collinear |-> radius != '0)
		else $error("zero radius on a proper triangle");

	// A clip flag needs some result sitting at the end of its range.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> cx_edge || cy_edge || &radius)
		else $error("saturated set with no clipped result");

	// The input side stalls only after an output beat was held.
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output back-pressure");

endmodule

bind triangle_circumcircle_unit_top tcu_props u_tcu_props (.*);
